// File: rtl/snm_pkg.sv
// Shared constants, types and register codes of the same-neighbour mask block.
`timescale 1ns / 1ps

package snm_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int TILE_BITS    = 8;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int WCNT_W       = $clog2(MAX_WIDTH + 1);
  localparam int LINE_W       = 2 * TILE_BITS;
  localparam int MAP_WIDTH_W  = 11;
  localparam int MAP_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int MASK_W       = 4;
  localparam int QUEUE_DEPTH  = 2;

  typedef logic [TILE_BITS-1:0]    tile_t;
  typedef logic [ADDR_W-1:0]       col_t;
  typedef logic [WCNT_W-1:0]       wcnt_t;
  typedef logic [MAP_WIDTH_W-1:0]  map_width_t;
  typedef logic [MAP_HEIGHT_W-1:0] map_height_t;
  typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;
  typedef logic [MASK_W-1:0]       mask_t;

  localparam cfg_index_t CFG_MAP_WIDTH  = 1'd0;
  localparam cfg_index_t CFG_MAP_HEIGHT = 1'd1;

  localparam logic KIND_TILE  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // bit positions within neighbour_mask
  localparam int MASK_N = 0;
  localparam int MASK_S = 1;
  localparam int MASK_W_BIT = 2;
  localparam int MASK_E = 3;

  localparam map_width_t  WIDTH_RESET  = 11'd16;
  localparam map_height_t HEIGHT_RESET = 16'd16;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    col_t  col;       // line buffer column
    logic  drain;     // drain step, no south neighbour
    tile_t tile;      // incoming code (south neighbour of the emitted tile)
    logic  emit;      // produces a result
    logic  north_ok;  // a north neighbour exists
    logic  east_ok;   // an east neighbour exists
    logic  last;      // final position of the map
  } op_t;

endpackage

// File: rtl/snm_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface snm_in_if;
  logic          valid;
  logic          ready;
  logic          kind;
  snm_pkg::tile_t tile_value;

  modport source (output valid, output kind, output tile_value, input ready);
  modport sink   (input valid, input kind, input tile_value, output ready);
endinterface

interface snm_out_if;
  logic           valid;
  logic           ready;
  snm_pkg::tile_t tile_code;
  snm_pkg::mask_t neighbour_mask;
  logic           last_of_map;

  modport source (output valid, output tile_code, output neighbour_mask,
                  output last_of_map, input ready);
  modport sink   (input valid, input tile_code, input neighbour_mask,
                  input last_of_map, output ready);
endinterface

// File: rtl/snm_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module snm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/snm_front.sv
// Front end: configuration registers, raster counters and request classification.
`timescale 1ns / 1ps

module snm_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  snm_pkg::cfg_index_t                cfg_index,
  input  logic [snm_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                               in_acc,
  input  logic                               in_kind,
  input  snm_pkg::tile_t                     in_tile,
  output logic                               push,
  output snm_pkg::op_t                       push_op
);

  snm_pkg::map_width_t  map_width_r;
  snm_pkg::map_height_t map_height_r;
  snm_pkg::col_t        col_r, col_nxt;
  snm_pkg::col_t        drain_r, drain_nxt;
  snm_pkg::map_height_t row_r, row_nxt;
  logic                 full_r, full_nxt;

  snm_pkg::wcnt_t       w_eff;
  snm_pkg::map_height_t h_eff;
  snm_pkg::col_t        cur_col;
  snm_pkg::wcnt_t       col_inc;
  logic                 is_tile;
  logic                 take;
  logic                 row_end;
  logic [snm_pkg::MAP_HEIGHT_W:0] row_inc;

  always_comb begin
    if (map_width_r == '0) begin
      w_eff = snm_pkg::wcnt_t'(1);
    end else if (32'(map_width_r) > snm_pkg::MAX_WIDTH) begin
      w_eff = snm_pkg::wcnt_t'(snm_pkg::MAX_WIDTH);
    end else begin
      w_eff = snm_pkg::wcnt_t'(map_width_r);
    end
    h_eff   = (map_height_r == '0) ? snm_pkg::map_height_t'(1) : map_height_r;

    is_tile = (in_kind == snm_pkg::KIND_TILE);
    // drop tiles once the map is complete and drains while it is filling
    take    = in_acc && (is_tile ? !full_r : full_r);
    cur_col = is_tile ? col_r : drain_r;
    col_inc = snm_pkg::wcnt_t'(cur_col) + snm_pkg::wcnt_t'(1);
    row_end = (col_inc >= w_eff);
    row_inc = {1'b0, row_r} + 1'b1;

    push             = take;
    push_op.col      = cur_col;
    push_op.drain    = !is_tile;
    push_op.tile     = in_tile;
    push_op.emit     = !is_tile || (row_r != '0);
    push_op.north_ok = (row_r >= snm_pkg::map_height_t'(2));
    push_op.east_ok  = !row_end;
    push_op.last     = !is_tile && row_end;

    col_nxt   = col_r;
    drain_nxt = drain_r;
    row_nxt   = row_r;
    full_nxt  = full_r;
    if (take) begin
      if (is_tile) begin
        if (row_end) begin
          col_nxt  = '0;
          row_nxt  = row_inc[snm_pkg::MAP_HEIGHT_W-1:0];
          full_nxt = (row_inc >= {1'b0, h_eff});
        end else begin
          col_nxt = col_inc[snm_pkg::ADDR_W-1:0];
        end
      end else begin
        if (row_end) begin
          drain_nxt = '0;
          col_nxt   = '0;
          row_nxt   = '0;
          full_nxt  = 1'b0;
        end else begin
          drain_nxt = col_inc[snm_pkg::ADDR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= snm_pkg::WIDTH_RESET;
      map_height_r <= snm_pkg::HEIGHT_RESET;
      col_r        <= '0;
      drain_r      <= '0;
      row_r        <= '0;
      full_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          snm_pkg::CFG_MAP_WIDTH:  map_width_r  <= cfg_wr_data[snm_pkg::MAP_WIDTH_W-1:0];
          snm_pkg::CFG_MAP_HEIGHT: map_height_r <= cfg_wr_data[snm_pkg::MAP_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      col_r   <= col_nxt;
      drain_r <= drain_nxt;
      row_r   <= row_nxt;
      full_r  <= full_nxt;
    end
  end

endmodule

// File: rtl/snm_fifo.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module snm_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  snm_pkg::op_t push_op,
  output logic         full,
  output logic         head_valid,
  output snm_pkg::op_t head_op,
  input  logic         pop
);

  localparam int PTR_W = (snm_pkg::QUEUE_DEPTH > 1) ? $clog2(snm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(snm_pkg::QUEUE_DEPTH + 1);

  snm_pkg::op_t     slot_r [snm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_W'(snm_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (32'(p) == snm_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/snm_back.sv
// Back end: line buffer access, mask compare and output register.
`timescale 1ns / 1ps

module snm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  snm_pkg::op_t   head_op,
  output logic           pop,
  output logic           out_valid,
  output snm_pkg::tile_t out_tile_code,
  output snm_pkg::mask_t out_mask,
  output logic           out_last,
  input  logic           out_ready
);

  // line entry: {upper, middle}
  typedef logic [snm_pkg::LINE_W-1:0] line_t;

  logic           b_valid_r;
  snm_pkg::op_t   b_op_r;
  logic           byp_v_r;
  snm_pkg::col_t  byp_addr_r;
  line_t          byp_data_r;
  snm_pkg::tile_t last_up_r;
  logic           out_valid_r;
  snm_pkg::tile_t out_tile_r;
  snm_pkg::mask_t out_mask_r;
  logic           out_last_r;

  line_t          rd_a, rd_b, cur, nbr, wr_data;
  snm_pkg::col_t  head_east, b_east;
  snm_pkg::tile_t up0, mid0, mid1;
  snm_pkg::mask_t mask;
  logic           out_free, b_go;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    b_go      = b_valid_r && (!b_op_r.emit || out_free);
    pop       = head_valid && (!b_valid_r || b_go);
    head_east = head_op.east_ok ? head_op.col + 1'b1 : head_op.col;
    b_east    = b_op_r.east_ok ? b_op_r.col + 1'b1 : b_op_r.col;

    // the write retired in the read cycle is not yet visible in the RAM output
    cur = (byp_v_r && byp_addr_r == b_op_r.col) ? byp_data_r : rd_a;
    nbr = (byp_v_r && byp_addr_r == b_east)     ? byp_data_r : rd_b;
    up0  = cur[snm_pkg::LINE_W-1:snm_pkg::TILE_BITS];
    mid0 = cur[snm_pkg::TILE_BITS-1:0];
    mid1 = nbr[snm_pkg::TILE_BITS-1:0];

    wr_data = {mid0, b_op_r.drain ? mid0 : b_op_r.tile};

    mask                     = '0;
    mask[snm_pkg::MASK_N]     = b_op_r.north_ok && (up0 == mid0);
    mask[snm_pkg::MASK_S]     = !b_op_r.drain && (b_op_r.tile == mid0);
    mask[snm_pkg::MASK_W_BIT] = (b_op_r.col != '0) && (last_up_r == mid0);
    mask[snm_pkg::MASK_E]     = b_op_r.east_ok && (mid1 == mid0);
  end

  snm_ram #(
    .WIDTH (snm_pkg::LINE_W),
    .DEPTH (snm_pkg::MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .we      (b_go),
    .waddr   (b_op_r.col),
    .wdata   (wr_data),
    .re      (pop),
    .raddr_a (head_op.col),
    .raddr_b (head_east),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op_r     <= head_op;
      byp_addr_r <= b_op_r.col;
      byp_data_r <= wr_data;
    end
    if (b_go) begin
      last_up_r <= mid0;
    end
    if (b_go && b_op_r.emit) begin
      out_tile_r <= mid0;
      out_mask_r <= mask;
      out_last_r <= b_op_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      byp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        b_valid_r <= 1'b1;
        byp_v_r   <= b_go;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
      if (b_go && b_op_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tile_code = out_tile_r;
  assign out_mask      = out_mask_r;
  assign out_last      = out_last_r;

endmodule

// File: rtl/raster_same_neighbour_mask.sv
// Top level of the four-neighbour same-code mask over a raster tile map.
`timescale 1ns / 1ps

// Tile codes of a map_width by map_height map enter in raster order, one
// request per clock while the queue has room, followed by map_width drain
// requests once the map is complete. Each result carries a tile code and its
// north/south/west/east same-code mask; results run one map row behind the
// requests, and the result for the final position has last_of_map set. The
// block sustains one request per clock while results are taken: a request is
// taken while an earlier result still waits in the output register, and the
// two-entry queue between front and back absorbs a stall on either side. A
// result becomes valid once the request that completes it has passed the
// queue, the registered read of the single line-buffer RAM and the output
// register. Tiles sent after the map is full and drains sent while it fills
// are dropped without a result. The line buffer needs no clearing after
// reset; program map_width and map_height while the block is idle.
module raster_same_neighbour_mask (
  input  logic                           clk,
  input  logic                           rst_n,
  snm_in_if.sink                         in_req,
  snm_out_if.source                      out_res,
  input  logic                           cfg_wr_en,
  input  snm_pkg::cfg_index_t            cfg_index,
  input  logic [snm_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

  logic         in_acc;
  logic         q_full;
  logic         q_push;
  snm_pkg::op_t q_push_op;
  logic         q_head_valid;
  snm_pkg::op_t q_head_op;
  logic         q_pop;

  // accept whenever the queue has room; dropped requests also pass here
  assign in_req.ready = !q_full;
  assign in_acc       = in_req.valid && !q_full;

  // classify and advance the raster counters
  snm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_acc      (in_acc),
    .in_kind     (in_req.kind),
    .in_tile     (in_req.tile_value),
    .push        (q_push),
    .push_op     (q_push_op)
  );

  // hold classified requests until the back end takes them
  snm_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_op    (q_head_op),
    .pop        (q_pop)
  );

  // read and update the line buffer, build the mask, drive the result
  snm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_head_valid),
    .head_op       (q_head_op),
    .pop           (q_pop),
    .out_valid     (out_res.valid),
    .out_tile_code (out_res.tile_code),
    .out_mask      (out_res.neighbour_mask),
    .out_last      (out_res.last_of_map),
    .out_ready     (out_res.ready)
  );

endmodule

// File: rtl/snm_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module snm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input snm_pkg::tile_t out_tile_code,
  input snm_pkg::mask_t out_mask,
  input logic           out_last
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a waiting result keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_tile_code) && $stable(out_mask) && $stable(out_last))
    else $error("result payload changed while stalled");

  // the final position sits on the bottom row and the last column
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      !out_mask[snm_pkg::MASK_S] && !out_mask[snm_pkg::MASK_E])
    else $error("final result shows a south or east neighbour");

endmodule

bind raster_same_neighbour_mask snm_checker u_snm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_tile_code (out_res.tile_code),
  .out_mask      (out_res.neighbour_mask),
  .out_last      (out_res.last_of_map)
);

// File: sim/raster_same_neighbour_mask_tb.sv
// Self-checking testbench for the four-neighbour same-code mask over a raster tile map.
`timescale 1ns / 1ps

module raster_same_neighbour_mask_tb;

  // Slowest correct run: about 1300 requests, each waiting out sender gaps and
  // receiver stalls, one receiver hold-off and a short settle per map.
  // CYCLE_LIMIT allows several times that run over.
  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 8;     // settle time for results still in flight, with margin
  localparam int DRAIN_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTS    = 100;

  typedef logic [snm_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    IDLE_SENDER_LIGHT,    // sender idles 32 %, receiver 52 %
    IDLE_RECEIVER_LIGHT,  // sender idles 52 %, receiver 32 %
    IDLE_NONE
  } idling_t;

  typedef struct packed {
    snm_pkg::tile_t code;
    snm_pkg::mask_t mask;
    logic           last;
  } mask_res_t;

  typedef struct packed {
    logic           setup;       // program both sizes before this request
    logic [15:0]    width_val;
    logic [15:0]    height_val;
    logic           kind;
    snm_pkg::tile_t tile;
    logic           typed;       // expected result written in the row
    mask_res_t      res;
  } dir_row_t;

  localparam mask_res_t NO_RES = '0;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  snm_pkg::cfg_index_t cfg_index;
  cfg_data_t cfg_wr_data;

  snm_in_if  req_if ();
  snm_out_if res_if ();

  raster_same_neighbour_mask DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (req_if),
    .out_res    (res_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // Directed part: reset state, the 1x1 map, out-of-range sizes, a uniform 2x2
  // map with every mask bit, then a mixed 3x3 map left to the predictor.
  dir_row_t dir_rows [25] = '{
    // drain straight after reset: map still filling, drop it
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h3C, 1'b0, NO_RES},
    // 1x1 map with the top code; a tile once full is dropped
    '{1'b1, 16'd1, 16'd1, snm_pkg::KIND_TILE,  8'hFF, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h00, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'hFF, 1'b1, '{8'hFF, 4'b0000, 1'b1}},
    // zero width and zero height both act as one
    '{1'b1, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h00, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h00, 1'b1, '{8'h00, 4'b0000, 1'b1}},
    // uniform 2x2 map: every existing neighbour matches
    '{1'b1, 16'd2, 16'd2, snm_pkg::KIND_TILE,  8'hA5, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h5A, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'hA5, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'hA5, 1'b1, '{8'hA5, 4'b1010, 1'b0}},  // S, E
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'hA5, 1'b1, '{8'hA5, 4'b0110, 1'b0}},  // S, W
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h00, 1'b1, '{8'hA5, 4'b1001, 1'b0}},  // N, E
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h00, 1'b1, '{8'hA5, 4'b0101, 1'b1}},  // N, W
    // mixed 3x3 map
    '{1'b1, 16'd3, 16'd3, snm_pkg::KIND_TILE,  8'h01, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h01, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h02, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h01, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h03, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h02, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h04, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h03, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_TILE,  8'h03, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h81, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h42, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, snm_pkg::KIND_DRAIN, 8'h18, 1'b0, NO_RES}
  };

  // Predictor state: the row being scored moves up into north_row as it is
  // emitted; centre_row holds the latest code of every column.
  snm_pkg::tile_t       north_row  [snm_pkg::MAX_WIDTH];
  snm_pkg::tile_t       centre_row [snm_pkg::MAX_WIDTH];
  int                   col_at;
  int                   rows_in;       // completed rows of the current map
  int                   drain_at;
  bit                   map_complete;
  snm_pkg::map_width_t  width_reg  = snm_pkg::WIDTH_RESET;
  snm_pkg::map_height_t height_reg = snm_pkg::HEIGHT_RESET;

  mask_res_t pending_masks [$];
  int        mismatch_count = 0;
  int        real_items     = 0;
  int        cycle_count    = 0;
  int        snd_pct        = 0;
  int        rcv_pct        = 0;
  bit        hold_request   = 1'b0;
  bit        hold_done      = 1'b0;

  // Tag travelling with each request: a written-in expectation replaces the
  // predicted one for that request.
  logic      typed_due;
  mask_res_t typed_res;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_width();
    if (width_reg == '0) return 1;
    if (width_reg > snm_pkg::MAX_WIDTH) return snm_pkg::MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int live_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  // Score column col of the row one behind the input, then move it up.
  // The west entry of north_row already holds this row's code.
  function automatic snm_pkg::mask_t score_column(input int col, input bit has_south,
                                                  input snm_pkg::tile_t south);
    snm_pkg::tile_t c;
    snm_pkg::mask_t m;
    c = centre_row[col];
    m = '0;
    if (rows_in >= 2 && north_row[col] == c) m[snm_pkg::MASK_N] = 1'b1;
    if (has_south && south == c) m[snm_pkg::MASK_S] = 1'b1;
    if (col > 0 && north_row[col-1] == c) m[snm_pkg::MASK_W_BIT] = 1'b1;
    if (col + 1 < live_width() && col + 1 < snm_pkg::MAX_WIDTH &&
        centre_row[col+1] == c)
      m[snm_pkg::MASK_E] = 1'b1;
    north_row[col] = c;
    return m;
  endfunction

  // Advance the predictor by one accepted request; return 1 with the result
  // it causes, 0 where the request is dropped or only fills the first row.
  function automatic bit predict_neighbour_mask(input logic kind,
                                                input snm_pkg::tile_t tile,
                                                output mask_res_t r);
    int col;
    int w;
    bit emitted;
    w = live_width();
    r = '0;
    if (kind == snm_pkg::KIND_TILE) begin
      if (map_complete) return 1'b0;
      col = (col_at >= snm_pkg::MAX_WIDTH) ? snm_pkg::MAX_WIDTH - 1 : col_at;
      emitted = (rows_in >= 1);
      if (emitted) begin
        r.code = centre_row[col];
        r.mask = score_column(col, 1'b1, tile);
      end else begin
        north_row[col] = centre_row[col];
      end
      centre_row[col] = tile;
      if (col + 1 >= w) begin
        col_at = 0;
        rows_in++;
        if (rows_in >= live_height()) map_complete = 1'b1;
      end else begin
        col_at = col + 1;
      end
      return emitted;
    end
    if (!map_complete) return 1'b0;
    col = (drain_at >= snm_pkg::MAX_WIDTH) ? snm_pkg::MAX_WIDTH - 1 : drain_at;
    r.code = centre_row[col];
    r.mask = score_column(col, 1'b0, '0);
    r.last = (col + 1 >= w);
    if (r.last) begin
      drain_at     = 0;
      col_at       = 0;
      rows_in      = 0;
      map_complete = 1'b0;
    end else begin
      drain_at = col + 1;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        snd_pct = 32;
        rcv_pct = 52;
      end
      IDLE_RECEIVER_LIGHT: begin
        snd_pct = 52;
        rcv_pct = 32;
      end
      default: begin
        snd_pct = 0;
        rcv_pct = 0;
      end
    endcase
  endtask

  // Offer one request and hold it until accepted. Valid stays high afterwards,
  // so the caller either offers the next request in the same step or drops valid.
  task automatic offer(input logic kind, input snm_pkg::tile_t tile, input logic typed,
                       input mask_res_t res);
    if ($urandom_range(0, 99) < snd_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_pct);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.tile_value <= tile;
    typed_due         <= typed;
    typed_res         <= res;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Wait until every expected result is back and the pipeline has settled;
  // the last request may have been one that causes no result.
  task automatic wait_quiet();
    do begin
      while (pending_masks.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_masks.size() != 0);
  endtask

  task automatic program_sizes(input int w, input int h);
    req_if.valid <= 1'b0;
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= snm_pkg::CFG_MAP_WIDTH;
    cfg_wr_data <= cfg_data_t'(w);
    @(posedge clk);
    cfg_index   <= snm_pkg::CFG_MAP_HEIGHT;
    cfg_wr_data <= cfg_data_t'(h);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    width_reg  = snm_pkg::map_width_t'(w);
    height_reg = snm_pkg::map_height_t'(h);
  endtask

  // Stream one whole map and its drain. With cut_rows > 0 the height register
  // is lowered to cut_height after that many rows, ending the map one row on.
  // Now and then slip in a drain while filling or a tile while full.
  task automatic run_map(input int w_val, input int h_val, input int cut_rows,
                         input int cut_height, input bit press);
    int             w;
    int             rows;
    int             r;
    int             c;
    bit             narrow;
    snm_pkg::tile_t palette [3];
    snm_pkg::tile_t code;
    program_sizes(w_val, h_val);
    w    = live_width();
    rows = (cut_rows > 0) ? cut_rows + 1 : live_height();
    // few codes per map, so that neighbours match often
    narrow = ($urandom_range(0, 3) != 0);
    foreach (palette[i]) palette[i] = snm_pkg::tile_t'($urandom_range(0, 255));
    for (r = 0; r < rows; r++) begin
      if (cut_rows > 0 && r == cut_rows) program_sizes(w_val, cut_height);
      if (press && r == 1) hold_request = 1'b1;
      for (c = 0; c < w; c++) begin
        if ($urandom_range(0, 15) == 0)
          offer(snm_pkg::KIND_DRAIN, snm_pkg::tile_t'($urandom_range(0, 255)), 1'b0,
                NO_RES);
        code = narrow ? palette[$urandom_range(0, 2)]
                      : snm_pkg::tile_t'($urandom_range(0, 255));
        offer(snm_pkg::KIND_TILE, code, 1'b0, NO_RES);
        real_items++;
      end
    end
    for (c = 0; c < w; c++) begin
      if ($urandom_range(0, 15) == 0)
        offer(snm_pkg::KIND_TILE, snm_pkg::tile_t'($urandom_range(0, 255)), 1'b0, NO_RES);
      offer(snm_pkg::KIND_DRAIN, snm_pkg::tile_t'($urandom_range(0, 255)), 1'b0, NO_RES);
      real_items++;
    end
  endtask

  // Compare each accepted result with the oldest expectation, then predict
  // for the request accepted at this edge.
  always @(posedge clk) begin : scoreboard
    mask_res_t got;
    mask_res_t want;
    mask_res_t predicted;
    bit        emitted;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.tile_code, res_if.neighbour_mask, res_if.last_of_map};
        if (pending_masks.size() == 0) begin
          report_mismatch("result with nothing expected", int'(got), 0);
        end else begin
          want = pending_masks.pop_front();
          if (got.code != want.code)
            report_mismatch("tile_code", got.code, want.code);
          if (got.mask != want.mask)
            report_mismatch("neighbour_mask", got.mask, want.mask);
          if (got.last != want.last)
            report_mismatch("last_of_map", got.last, want.last);
        end
      end
      if (req_if.valid && req_if.ready) begin
        emitted = predict_neighbour_mask(req_if.kind, req_if.tile_value, predicted);
        if (typed_due) pending_masks.push_back(typed_res);
        else if (emitted) pending_masks.push_back(predicted);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off while the sender keeps
  // offering, so the block fills and stalls its input.
  initial begin : result_sink
    int held;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        res_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= rcv_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int w_val;
    int h_val;
    int cut;
    int n;
    req_if.valid      <= 1'b0;
    req_if.kind       <= snm_pkg::KIND_TILE;
    req_if.tile_value <= '0;
    typed_due         <= 1'b0;
    typed_res         <= NO_RES;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= snm_pkg::CFG_MAP_WIDTH;
    cfg_wr_data       <= '0;
    rst_n             <= 1'b0;
    col_at       = 0;
    rows_in      = 0;
    drain_at     = 0;
    map_complete = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_SENDER_LIGHT);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setup)
        program_sizes(int'(dir_rows[i].width_val), int'(dir_rows[i].height_val));
      offer(dir_rows[i].kind, dir_rows[i].tile, dir_rows[i].typed, dir_rows[i].res);
    end

    // first random map carries the long receiver hold-off
    run_map(6, 4, 0, 0, 1'b1);

    while (real_items < RANDOM_ITEMS) begin
      if (real_items >= 2 * RANDOM_ITEMS / 3) set_idling(IDLE_NONE);
      else if (real_items >= RANDOM_ITEMS / 3) set_idling(IDLE_RECEIVER_LIGHT);
      pick  = $urandom_range(0, 7);
      w_val = $urandom_range(1, 12);
      h_val = $urandom_range(1, 6);
      if (pick == 0) w_val = 0;
      if (pick == 1) h_val = 0;
      if (pick == 3) w_val = $urandom_range(13, 64);
      if (pick == 2) begin
        // tallest height, cut short mid-map by lowering the register
        cut = $urandom_range(1, 4);
        run_map(w_val, 16'hFFFF, cut, $urandom_range(0, cut), 1'b0);
      end else begin
        run_map(w_val, h_val, 0, 0, 1'b0);
      end
    end

    req_if.valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pending_masks.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_masks.size() != 0)
      report_mismatch("expected results never delivered", pending_masks.size(), 0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/snm_pkg.sv
rtl/snm_if.sv
rtl/snm_ram.sv
rtl/snm_front.sv
rtl/snm_fifo.sv
rtl/snm_back.sv
rtl/raster_same_neighbour_mask.sv
rtl/snm_checker.sv
sim/raster_same_neighbour_mask_tb.sv
